/* hw/rtl/pcb_pkg.sv */
package pcb_pkg;

  localparam int CHANNELS = 2;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 16;
  localparam int THR_W      = 23;
  localparam int RATIO_W    = 15;
  localparam int MAKEUP_W   = 16;
  localparam int BLEND_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND     = 3'd5;

  localparam logic [COEF_W-1:0]   RST_ATTACK    = 16'd65000;
  localparam logic [COEF_W-1:0]   RST_RELEASE   = 16'd65500;
  localparam logic [THR_W-1:0]    RST_THRESHOLD = 23'd8388607;
  localparam logic [RATIO_W-1:0]  RST_RATIO     = 15'd256;
  localparam logic [MAKEUP_W-1:0] RST_MAKEUP    = 16'd4096;
  localparam logic [BLEND_W-1:0]  RST_BLEND     = 17'd65536;

  // datapath widths
  localparam int GAIN_W  = 25;   // Q1.24 gain, up to 1.0
  localparam int WET_W   = 28;
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W;

  // shared divider
  localparam int DIV_W       = 48;
  localparam int DIVR_W      = 24;
  localparam int DIV_BITS    = 2;   // quotient bits per cycle
  localparam int DIV_CYC     = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYC + 1);

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 5'd0;
  localparam logic [STEP_W-1:0] STEP_UNITY = 5'd11;
  localparam logic [STEP_W-1:0] STEP_MUL_G = 5'd12;

  typedef struct packed {
    logic [COEF_W-1:0]   attack;
    logic [COEF_W-1:0]   release_c;
    logic [THR_W-1:0]    threshold;
    logic [RATIO_W-1:0]  ratio;
    logic [MAKEUP_W-1:0] makeup;
    logic [BLEND_W-1:0]  blend;
  } cfg_t;

  typedef enum logic [1:0] {
    MA_ENV, MA_ABS, MA_COMP, MA_WET
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_COEF, MB_COEF_INV, MB_GAIN, MB_MAKEUP, MB_BLEND_INV, MB_BLEND
  } mul_b_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_INIT_R12, ACC_INIT_R16, ACC_INIT_R24, ACC_ADD
  } acc_op_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_ENV, DST_GAIN_Q, DST_GAIN_ONE, DST_COMP, DST_WET, DST_OUT
  } dst_e;

  typedef enum logic [1:0] {
    DIV_NONE, DIV_LEVEL, DIV_GAIN
  } div_op_e;

  typedef enum logic [2:0] {
    SEQ_WAIT_IN, SEQ_NEXT, SEQ_WAIT_DIV, SEQ_JUMP, SEQ_JUMP_LE, SEQ_WAIT_OUT
  } seq_e;

  typedef struct packed {
    seq_e              seq;
    logic [STEP_W-1:0] target;
    mul_a_e            ma;
    mul_b_e            mb;
    acc_op_e           acc;
    dst_e              dst;
    div_op_e           div;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic div_busy;
    logic env_le;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  function automatic ctrl_t cw(input seq_e seq, input logic [STEP_W-1:0] target,
                               input mul_a_e ma, input mul_b_e mb, input acc_op_e acc,
                               input dst_e dst, input div_op_e div);
    ctrl_t c;
    c.seq    = seq;
    c.target = target;
    c.ma     = ma;
    c.mb     = mb;
    c.acc    = acc;
    c.dst    = dst;
    c.div    = div;
    return c;
  endfunction

  // microprogram; a multiply issued in step n is accumulated in step n+1
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    case (step)
      5'd0:  c = cw(SEQ_WAIT_IN,  STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_HOLD,     DST_NONE,
                    DIV_NONE);
      // envelope smoother
      5'd1:  c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_INIT_R16, DST_NONE,
                    DIV_NONE);
      5'd2:  c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ABS,  MB_COEF_INV,  ACC_ADD,      DST_NONE,
                    DIV_NONE);
      5'd3:  c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_ADD,      DST_NONE,
                    DIV_NONE);
      5'd4:  c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_HOLD,     DST_ENV,
                    DIV_NONE);
      // gain computer
      5'd5:  c = cw(SEQ_JUMP_LE,  STEP_UNITY, MA_ENV,  MB_COEF,      ACC_HOLD,     DST_NONE,
                    DIV_NONE);
      5'd6:  c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_HOLD,     DST_NONE,
                    DIV_LEVEL);
      5'd7:  c = cw(SEQ_WAIT_DIV, STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_HOLD,     DST_NONE,
                    DIV_NONE);
      5'd8:  c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_HOLD,     DST_NONE,
                    DIV_GAIN);
      5'd9:  c = cw(SEQ_WAIT_DIV, STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_HOLD,     DST_NONE,
                    DIV_NONE);
      5'd10: c = cw(SEQ_JUMP,     STEP_MUL_G, MA_ENV,  MB_COEF,      ACC_HOLD,     DST_GAIN_Q,
                    DIV_NONE);
      5'd11: c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_HOLD,     DST_GAIN_ONE,
                    DIV_NONE);
      // compressed path, makeup, blend
      5'd12: c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ABS,  MB_GAIN,      ACC_INIT_R24, DST_NONE,
                    DIV_NONE);
      5'd13: c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_ADD,      DST_NONE,
                    DIV_NONE);
      5'd14: c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_HOLD,     DST_COMP,
                    DIV_NONE);
      5'd15: c = cw(SEQ_NEXT,     STEP_IDLE,  MA_COMP, MB_MAKEUP,    ACC_INIT_R12, DST_NONE,
                    DIV_NONE);
      5'd16: c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_ADD,      DST_NONE,
                    DIV_NONE);
      5'd17: c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_HOLD,     DST_WET,
                    DIV_NONE);
      5'd18: c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ABS,  MB_BLEND_INV, ACC_INIT_R16, DST_NONE,
                    DIV_NONE);
      5'd19: c = cw(SEQ_NEXT,     STEP_IDLE,  MA_WET,  MB_BLEND,     ACC_ADD,      DST_NONE,
                    DIV_NONE);
      5'd20: c = cw(SEQ_NEXT,     STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_ADD,      DST_NONE,
                    DIV_NONE);
      5'd21: c = cw(SEQ_WAIT_OUT, STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_HOLD,     DST_OUT,
                    DIV_NONE);
      default: c = cw(SEQ_JUMP,   STEP_IDLE,  MA_ENV,  MB_COEF,      ACC_HOLD,     DST_NONE,
                      DIV_NONE);
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/pcb_sequencer.sv */
module pcb_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pcb_pkg::stat_t stat_i,
  output pcb_pkg::ctrl_t ctrl_o
);

  logic [pcb_pkg::STEP_W-1:0] step_q, step_d;
  logic [pcb_pkg::STEP_W-1:0] step_inc;

  assign ctrl_o   = pcb_pkg::ucode(step_q);
  assign step_inc = step_q + pcb_pkg::STEP_W'(1);

  always_comb begin
    step_d = step_q;
    unique case (ctrl_o.seq)
      pcb_pkg::SEQ_WAIT_IN:  if (stat_i.start) step_d = step_inc;
      pcb_pkg::SEQ_NEXT:     step_d = step_inc;
      pcb_pkg::SEQ_WAIT_DIV: if (!stat_i.div_busy) step_d = step_inc;
      pcb_pkg::SEQ_JUMP:     step_d = ctrl_o.target;
      pcb_pkg::SEQ_JUMP_LE:  step_d = stat_i.env_le ? ctrl_o.target : step_inc;
      pcb_pkg::SEQ_WAIT_OUT: if (stat_i.out_free) step_d = ctrl_o.target;
      default:               step_d = pcb_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= pcb_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

/* hw/rtl/pcb_divider.sv */
module pcb_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pcb_pkg::div_req_t         req_i,
  output logic                      busy_o,
  output logic [pcb_pkg::DIV_W-1:0] quotient_o
);

  logic [pcb_pkg::DIV_W-1:0]     quo_q, quo_d;
  logic [pcb_pkg::DIVR_W-1:0]    rem_q, rem_d;
  logic [pcb_pkg::DIVR_W-1:0]    den_q;
  logic [pcb_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [pcb_pkg::DIVR_W:0] ext;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < pcb_pkg::DIV_BITS; i++) begin
      ext   = {rem_d, quo_d[pcb_pkg::DIV_W-1]};
      quo_d = {quo_d[pcb_pkg::DIV_W-2:0], 1'b0};
      if (ext >= {1'b0, den_q}) begin
        ext      = ext - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end
      rem_d = ext[pcb_pkg::DIVR_W-1:0];
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      cnt_d  = pcb_pkg::DIV_CNT_W'(pcb_pkg::DIV_CYC);
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d  = cnt_q - pcb_pkg::DIV_CNT_W'(1);
      busy_d = (cnt_q != pcb_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

/* hw/rtl/pcb_datapath.sv */
module pcb_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pcb_pkg::ctrl_t               ctrl_i,
  input  pcb_pkg::cfg_t                cfg_i,
  input  logic                         start_i,
  input  logic                         channel_i,
  input  logic [pcb_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [pcb_pkg::DIV_W-1:0]    quotient_i,
  output pcb_pkg::div_req_t            div_req_o,
  output logic                         env_le_o,
  output logic                         out_free_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         out_channel_o,
  output logic [pcb_pkg::SAMPLE_W-1:0] sample_o
);

  localparam int SW = pcb_pkg::SAMPLE_W;
  localparam int MAG_W = pcb_pkg::ACC_W - 16;

  logic [SW-1:0] env_q [pcb_pkg::CHANNELS];

  logic [pcb_pkg::CH_IDX_W-1:0] in_idx, idx_q;
  logic [SW-1:0]                in_abs, env_rd;
  logic [pcb_pkg::COEF_W-1:0]   in_coef;

  logic [SW-1:0]                a_q, e_q, comp_q;
  logic                         neg_q, chan_q;
  logic [pcb_pkg::COEF_W-1:0]   c_q;
  logic [pcb_pkg::GAIN_W-1:0]   g_q;
  logic [pcb_pkg::WET_W-1:0]    wet_q;

  logic [pcb_pkg::RATIO_W-1:0]  ratio_eff;
  logic [pcb_pkg::BLEND_W-1:0]  blend_eff, blend_inv, coef_inv;

  logic [pcb_pkg::MUL_A_W-1:0]  mul_a;
  logic [pcb_pkg::MUL_B_W-1:0]  mul_b;
  logic [pcb_pkg::PROD_W-1:0]   prod, p_q;
  logic [pcb_pkg::ACC_W-1:0]    acc_q, acc_d;

  logic [SW-1:0]                env_new, level, env_diff, sat_mag;
  logic [MAG_W-1:0]             mag;
  logic                         out_load, out_valid_q;
  logic                         out_chan_q;
  logic [SW-1:0]                out_q;

  // item capture
  assign in_idx  = (32'(channel_i) < pcb_pkg::CHANNELS) ? pcb_pkg::CH_IDX_W'(channel_i)
                                                        : pcb_pkg::CH_IDX_W'(pcb_pkg::CHANNELS - 1);
  assign in_abs  = sample_i[SW-1] ? (~sample_i + SW'(1)) : sample_i;
  assign env_rd  = env_q[in_idx];
  assign in_coef = (in_abs > env_rd) ? cfg_i.attack : cfg_i.release_c;

  // register clamps
  assign ratio_eff = (cfg_i.ratio < pcb_pkg::RATIO_W'(256)) ? pcb_pkg::RATIO_W'(256) : cfg_i.ratio;
  assign blend_eff = (cfg_i.blend > pcb_pkg::BLEND_W'(65536)) ? pcb_pkg::BLEND_W'(65536)
                                                               : cfg_i.blend;
  assign blend_inv = pcb_pkg::BLEND_W'(65536) - blend_eff;
  assign coef_inv  = pcb_pkg::BLEND_W'(65536) - {1'b0, c_q};

  // multiplier operands
  always_comb begin
    unique case (ctrl_i.ma)
      pcb_pkg::MA_ENV:  mul_a = pcb_pkg::MUL_A_W'(e_q);
      pcb_pkg::MA_ABS:  mul_a = pcb_pkg::MUL_A_W'(a_q);
      pcb_pkg::MA_COMP: mul_a = pcb_pkg::MUL_A_W'(comp_q);
      pcb_pkg::MA_WET:  mul_a = wet_q;
      default:          mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.mb)
      pcb_pkg::MB_COEF:      mul_b = pcb_pkg::MUL_B_W'(c_q);
      pcb_pkg::MB_COEF_INV:  mul_b = pcb_pkg::MUL_B_W'(coef_inv);
      pcb_pkg::MB_GAIN:      mul_b = g_q;
      pcb_pkg::MB_MAKEUP:    mul_b = pcb_pkg::MUL_B_W'(cfg_i.makeup);
      pcb_pkg::MB_BLEND_INV: mul_b = pcb_pkg::MUL_B_W'(blend_inv);
      pcb_pkg::MB_BLEND:     mul_b = pcb_pkg::MUL_B_W'(blend_eff);
      default:               mul_b = '0;
    endcase
  end

  assign prod = pcb_pkg::PROD_W'(mul_a) * pcb_pkg::PROD_W'(mul_b);

  // accumulator, seeded with the rounding half of the following shift
  always_comb begin
    unique case (ctrl_i.acc)
      pcb_pkg::ACC_HOLD:     acc_d = acc_q;
      pcb_pkg::ACC_INIT_R12: acc_d = pcb_pkg::ACC_W'(1) << 11;
      pcb_pkg::ACC_INIT_R16: acc_d = pcb_pkg::ACC_W'(1) << 15;
      pcb_pkg::ACC_INIT_R24: acc_d = pcb_pkg::ACC_W'(1) << 23;
      pcb_pkg::ACC_ADD:      acc_d = acc_q + p_q;
      default:               acc_d = acc_q;
    endcase
  end

  assign env_new  = acc_q[SW+15:16];
  assign env_le_o = (e_q <= {1'b0, cfg_i.threshold});
  assign env_diff = e_q - {1'b0, cfg_i.threshold};
  assign level    = {1'b0, cfg_i.threshold} + quotient_i[SW-1:0];

  // divider requests: (e-T)*256/ratio, then level*2^24/max(e,1)
  always_comb begin
    div_req_o.start    = (ctrl_i.div != pcb_pkg::DIV_NONE);
    div_req_o.dividend = '0;
    div_req_o.divisor  = '0;
    unique case (ctrl_i.div)
      pcb_pkg::DIV_LEVEL: begin
        div_req_o.dividend = pcb_pkg::DIV_W'({env_diff, 8'd0});
        div_req_o.divisor  = pcb_pkg::DIVR_W'(ratio_eff);
      end
      pcb_pkg::DIV_GAIN: begin
        div_req_o.dividend = {level, 24'd0};
        div_req_o.divisor  = (e_q == '0) ? pcb_pkg::DIVR_W'(1) : e_q;
      end
      default: ;
    endcase
  end

  // output saturation
  assign mag = acc_q[pcb_pkg::ACC_W-1:16];
  always_comb begin
    if (neg_q) begin
      sat_mag = (mag > MAG_W'(24'h800000)) ? 24'h800000 : mag[SW-1:0];
    end else begin
      sat_mag = (mag > MAG_W'(24'h7FFFFF)) ? 24'h7FFFFF : mag[SW-1:0];
    end
  end

  assign out_free_o = !out_valid_q || out_ready_i;
  assign out_load   = (ctrl_i.dst == pcb_pkg::DST_OUT) && out_free_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pcb_pkg::CHANNELS; i++) env_q[i] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.dst == pcb_pkg::DST_ENV) env_q[idx_q] <= env_new;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= prod;
    acc_q <= acc_d;
    if (start_i) begin
      a_q    <= in_abs;
      neg_q  <= sample_i[SW-1];
      chan_q <= channel_i;
      idx_q  <= in_idx;
      e_q    <= env_rd;
      c_q    <= in_coef;
    end
    case (ctrl_i.dst)
      pcb_pkg::DST_ENV:      e_q    <= env_new;
      pcb_pkg::DST_GAIN_Q:   g_q    <= quotient_i[pcb_pkg::GAIN_W-1:0];
      pcb_pkg::DST_GAIN_ONE: g_q    <= pcb_pkg::GAIN_W'(1) << 24;
      pcb_pkg::DST_COMP:     comp_q <= acc_q[SW+23:24];
      pcb_pkg::DST_WET:      wet_q  <= acc_q[pcb_pkg::WET_W+11:12];
      default: ;
    endcase
    if (out_load) begin
      out_chan_q <= chan_q;
      out_q      <= neg_q ? (~sat_mag + SW'(1)) : sat_mag;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_chan_q;
  assign sample_o      = out_q;

endmodule

/* hw/rtl/peak_compressor_with_blend.sv */
// Feed-forward peak compressor with makeup gain and dry/wet blend, two channels.
// s_axis: one Q1.23 sample per transaction in tdata, channel number in tuser.
// m_axis: the processed sample with the same channel number in tuser.
// cfg: register writes (index, data), always ready; write only while idle.
// Each sample updates that channel's peak envelope, then a microprogram runs
// the gain computer and the output path on one shared multiplier, with an
// iterative divider producing two quotient bits per cycle.
// Latency from input transaction to m_axis_tvalid is shorter when the
// envelope is at or below the threshold, since the gain computer then skips
// both divider runs. One sample is in work at a time; s_axis_tready rises
// at the edge that loads the result into the output register.
// A result waiting in the output register does not block the next sample;
// if the receiver stalls, the next result holds at the last microcode step.
// Reset clears the envelopes to zero, loads the register defaults and
// returns the sequencer to idle.
module peak_compressor_with_blend (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [pcb_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [23:0] sample_in
  input  logic                            s_axis_tuser,   // [0] channel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pcb_pkg::SAMPLE_W-1:0]    m_axis_tdata,   // [23:0] sample_out
  output logic                            m_axis_tuser,   // [0] out_channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pcb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  pcb_pkg::cfg_t     cfg_q;
  pcb_pkg::ctrl_t    ctrl;
  pcb_pkg::stat_t    stat;
  pcb_pkg::div_req_t div_req;
  logic                         div_busy;
  logic [pcb_pkg::DIV_W-1:0]    quotient;
  logic                         in_start, env_le, out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack    <= pcb_pkg::RST_ATTACK;
      cfg_q.release_c <= pcb_pkg::RST_RELEASE;
      cfg_q.threshold <= pcb_pkg::RST_THRESHOLD;
      cfg_q.ratio     <= pcb_pkg::RST_RATIO;
      cfg_q.makeup    <= pcb_pkg::RST_MAKEUP;
      cfg_q.blend     <= pcb_pkg::RST_BLEND;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pcb_pkg::REG_ATTACK:    cfg_q.attack    <= cfg_data_i[pcb_pkg::COEF_W-1:0];
        pcb_pkg::REG_RELEASE:   cfg_q.release_c <= cfg_data_i[pcb_pkg::COEF_W-1:0];
        pcb_pkg::REG_THRESHOLD: cfg_q.threshold <= cfg_data_i[pcb_pkg::THR_W-1:0];
        pcb_pkg::REG_RATIO:     cfg_q.ratio     <= cfg_data_i[pcb_pkg::RATIO_W-1:0];
        pcb_pkg::REG_MAKEUP:    cfg_q.makeup    <= cfg_data_i[pcb_pkg::MAKEUP_W-1:0];
        pcb_pkg::REG_BLEND:     cfg_q.blend     <= cfg_data_i[pcb_pkg::BLEND_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (ctrl.seq == pcb_pkg::SEQ_WAIT_IN);
  assign in_start      = s_axis_tvalid && s_axis_tready;

  assign stat.start    = in_start;
  assign stat.div_busy = div_busy;
  assign stat.env_le   = env_le;
  assign stat.out_free = out_free;

  pcb_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  pcb_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  pcb_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg_q),
    .start_i       (in_start),
    .channel_i     (s_axis_tuser),
    .sample_i      (s_axis_tdata),
    .quotient_i    (quotient),
    .div_req_o     (div_req),
    .env_le_o      (env_le),
    .out_free_o    (out_free),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_channel_o (m_axis_tuser),
    .sample_o      (m_axis_tdata)
  );

  // a divide is never issued on top of a running one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_busy)
    else $error("divider restarted while busy");

  // the divider's busy flag drops exactly at the end of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> ##(pcb_pkg::DIV_CYC) div_busy ##1 !div_busy)
    else $error("divider run length wrong");

  // the sequencer leaves idle on every accepted sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_start |=> !s_axis_tready)
    else $error("sequencer did not start on input transaction");

endmodule

/* tb/sv/pcb_sample_checker.sv */
module pcb_sample_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [pcb_pkg::SAMPLE_W-1:0]    s_tdata_i,
  input  logic                            s_tuser_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [pcb_pkg::SAMPLE_W-1:0]    m_tdata_i,
  input  logic                            m_tuser_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [pcb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pcb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned                     errors_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                         ch;
    logic [pcb_pkg::SAMPLE_W-1:0] smp;
  } out_sample_t;

  pcb_pkg::cfg_t                cfg_q;
  logic [pcb_pkg::SAMPLE_W-1:0] env_q [pcb_pkg::CHANNELS];
  out_sample_t                  due_q [$];
  out_sample_t                  want;
  int unsigned                  err_cnt = 0;

  // Envelope update, gain computer, makeup and blend for one sample.
  function automatic logic [pcb_pkg::SAMPLE_W-1:0] compress_sample(
      input logic ch, input logic [pcb_pkg::SAMPLE_W-1:0] raw);
    logic        neg;
    logic [63:0] a, e, c, t, r, b, gain, level, comp, wet, mag;
    int          idx;
    neg = raw[pcb_pkg::SAMPLE_W-1];
    a   = neg ? (64'h1000000 - 64'(raw)) : 64'(raw);
    idx = (int'(ch) < pcb_pkg::CHANNELS) ? int'(ch) : pcb_pkg::CHANNELS - 1;
    e   = 64'(env_q[idx]);
    c   = (a > e) ? 64'(cfg_q.attack) : 64'(cfg_q.release_c);
    t   = 64'(cfg_q.threshold);
    r   = (cfg_q.ratio < 256) ? 64'd256 : 64'(cfg_q.ratio);
    b   = (cfg_q.blend > 65536) ? 64'd65536 : 64'(cfg_q.blend);
    e   = (c * e + (64'd65536 - c) * a + 64'd32768) >> 16;
    e   = e & 64'hFFFFFF;
    env_q[idx] = e[pcb_pkg::SAMPLE_W-1:0];
    gain = 64'd1 << 24;
    if (e > t) begin
      level = t + ((e - t) * 64'd256) / r;
      gain  = (level << 24) / ((e < 64'd1) ? 64'd1 : e);
    end
    comp = (a * gain + (64'd1 << 23)) >> 24;
    wet  = (comp * 64'(cfg_q.makeup) + 64'd2048) >> 12;
    mag  = (a * (64'd65536 - b) + wet * b + 64'd32768) >> 16;
    if (neg) begin
      if (mag > 64'd8388608) mag = 64'd8388608;
      mag = 64'h1000000 - mag;
    end else begin
      if (mag > 64'd8388607) mag = 64'd8388607;
    end
    return mag[pcb_pkg::SAMPLE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q = '{pcb_pkg::RST_ATTACK, pcb_pkg::RST_RELEASE, pcb_pkg::RST_THRESHOLD,
                pcb_pkg::RST_RATIO, pcb_pkg::RST_MAKEUP, pcb_pkg::RST_BLEND};
      for (int i = 0; i < pcb_pkg::CHANNELS; i++) env_q[i] = '0;
      due_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          pcb_pkg::REG_ATTACK:    cfg_q.attack    = cfg_data_i[pcb_pkg::COEF_W-1:0];
          pcb_pkg::REG_RELEASE:   cfg_q.release_c = cfg_data_i[pcb_pkg::COEF_W-1:0];
          pcb_pkg::REG_THRESHOLD: cfg_q.threshold = cfg_data_i[pcb_pkg::THR_W-1:0];
          pcb_pkg::REG_RATIO:     cfg_q.ratio     = cfg_data_i[pcb_pkg::RATIO_W-1:0];
          pcb_pkg::REG_MAKEUP:    cfg_q.makeup    = cfg_data_i[pcb_pkg::MAKEUP_W-1:0];
          pcb_pkg::REG_BLEND:     cfg_q.blend     = cfg_data_i[pcb_pkg::BLEND_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected output transaction, expected none, actual ch %0d data %06h",
                   $time, m_tuser_i, m_tdata_i);
          err_cnt++;
        end else begin
          want = due_q.pop_front();
          if (m_tuser_i !== want.ch) begin
            $display("%0t: channel mismatch, expected %0d, actual %0d",
                     $time, want.ch, m_tuser_i);
            err_cnt++;
          end
          if (m_tdata_i !== want.smp) begin
            $display("%0t: sample mismatch (ch %0d), expected %06h, actual %06h",
                     $time, want.ch, want.smp, m_tdata_i);
            err_cnt++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        want.ch  = s_tuser_i;
        want.smp = compress_sample(s_tuser_i, s_tdata_i);
        due_q.push_back(want);
      end
      pending_o <= due_q.size();
    end
  end

  assign errors_o = err_cnt;

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 80;
  localparam int CYCLE_LIMIT     = 1000000;

  // indexes past the register list; writes there must be dropped
  localparam logic [pcb_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [pcb_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [pcb_pkg::SAMPLE_W-1:0]   s_axis_tdata  = '0;
  logic                           s_axis_tuser  = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [pcb_pkg::SAMPLE_W-1:0]   m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [pcb_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [pcb_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycles   = 0;
  bit          src_idle  = 1'b1;
  bit          sink_idle = 1'b1;
  bit          hold_req  = 1'b0;

  peak_compressor_with_blend i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pcb_sample_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // valid stays high across back-to-back writes; caller drops it
  task automatic write_reg(input logic [pcb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pcb_pkg::CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_settings(input logic [pcb_pkg::CFG_DATA_W-1:0] att, rel, thr, rat,
                               mak, bln);
    write_reg(pcb_pkg::REG_ATTACK, att);
    write_reg(pcb_pkg::REG_RELEASE, rel);
    write_reg(pcb_pkg::REG_THRESHOLD, thr);
    write_reg(pcb_pkg::REG_RATIO, rat);
    write_reg(pcb_pkg::REG_MAKEUP, mak);
    write_reg(pcb_pkg::REG_BLEND, bln);
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
              pcb_pkg::CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_sample(input logic ch, input logic [pcb_pkg::SAMPLE_W-1:0] smp);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // extremes, in-range values and the odd out-of-range code; junk above the field sometimes
  function automatic logic [pcb_pkg::CFG_DATA_W-1:0] rand_reg(input int w, input int lo,
                                                              input int hi);
    logic [pcb_pkg::CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = pcb_pkg::CFG_DATA_W'(lo);
      1:       v = pcb_pkg::CFG_DATA_W'(hi);
      2:       v = pcb_pkg::CFG_DATA_W'($urandom_range(0, (1 << w) - 1));
      default: v = pcb_pkg::CFG_DATA_W'($urandom_range(lo, hi));
    endcase
    if (w < pcb_pkg::CFG_DATA_W && $urandom_range(0, 3) == 0)
      v = v | pcb_pkg::CFG_DATA_W'($urandom << w);
    return v;
  endfunction

  initial begin : sink_proc
    int n;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 9);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stim_proc
    logic [pcb_pkg::CFG_DATA_W-1:0] thr;
    logic [pcb_pkg::SAMPLE_W-1:0]   smp;
    int                             loud;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: unity gain, fully wet
    push_sample(1'b0, 24'h000000);
    push_sample(1'b0, 24'h7FFFFF);
    push_sample(1'b1, 24'h800000);
    push_sample(1'b1, 24'hFFFFFF);
    push_sample(1'b0, 24'h000001);
    push_sample(1'b1, 24'h400000);
    drain();

    // instant envelope, zero threshold, ratio code 0, max makeup, blend code over one
    load_settings(23'd0, 23'd0, 23'd0, 23'd0, 23'd65535, 23'h1FFFF);
    push_sample(1'b0, 24'h7FFFFF);
    push_sample(1'b0, 24'h800000);
    push_sample(1'b1, 24'h7FFFFF);
    push_sample(1'b1, 24'h800000);
    push_sample(1'b0, 24'h000001);
    push_sample(1'b1, 24'hFFFFFF);
    drain();

    // fast attack, frozen release, heavy ratio, half blend
    load_settings(23'd1000, 23'd65535, 23'h100000, 23'd16384, 23'd0, 23'd32768);
    push_sample(1'b0, 24'h800000);
    push_sample(1'b0, 24'h7FFFFF);
    push_sample(1'b0, 24'h800000);
    push_sample(1'b1, 24'h000010);
    push_sample(1'b0, 24'h000000);
    drain();

    // envelope just past the top threshold, largest ratio code
    load_settings(23'd0, 23'd65535, 23'd8388607, 23'h7FFF, 23'd4096, 23'd65536);
    push_sample(1'b0, 24'h800000);
    push_sample(1'b0, 24'h7FFFFF);
    push_sample(1'b1, 24'h800000);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      thr = rand_reg(pcb_pkg::THR_W, 0, 8388607);
      if ($urandom_range(0, 1) == 1) thr = thr >> $urandom_range(1, 16);
      load_settings(rand_reg(pcb_pkg::COEF_W, 0, 65535), rand_reg(pcb_pkg::COEF_W, 0, 65535),
                    thr, rand_reg(pcb_pkg::RATIO_W, 256, 16384),
                    rand_reg(pcb_pkg::MAKEUP_W, 0, 65535),
                    rand_reg(pcb_pkg::BLEND_W, 0, 65536));
      src_idle  = (ph < PHASES - 1);
      sink_idle = (ph < PHASES - 1);
      if (ph == 2) hold_req = 1'b1;
      loud = $urandom_range(0, 10);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        case ($urandom_range(0, 15))
          0:       smp = 24'h7FFFFF;
          1:       smp = 24'h800000;
          2:       smp = 24'h000000;
          default: begin
            smp = pcb_pkg::SAMPLE_W'($urandom);
            smp = $signed(smp) >>> (loud + $urandom_range(0, 3));
          end
        endcase
        push_sample(1'($urandom_range(0, 1)), smp);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
